[rtl/mxt_pkg.sv]
// Package for the maximum-XOR-pair trie block.
// Holds sizing constants and the command and status structs shared by the
// controller and the datapath. Depends on nothing.
package mxt_pkg;

    // Width of the value ports and of the xor results.
    localparam int DATA_W     = 32;
    // Number of value bits used, one trie level per bit.
    localparam int VALUE_BITS = 32;
    // Largest number of values a set is sized for.
    localparam int MAX_VALUES = 1024;
    // Number of non-root nodes in the node store.
    localparam int NODE_CAP   = MAX_VALUES * VALUE_BITS;
    // Node index width; index 0 stands for the root and for a null child.
    localparam int IDX_W      = $clog2(NODE_CAP + 1);
    // Width of the node counter, which reaches NODE_CAP + 1.
    localparam int CNT_W      = $clog2(NODE_CAP + 2);
    // Width of the level counter.
    localparam int LVL_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    // One node word holds both child indices: child 1 above child 0.
    localparam int NODE_W     = 2 * IDX_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // Capture the incoming word and start the walk.
        logic walk_step;   // Follow the value's own path one level.
        logic link;        // Hook the first new node onto its parent.
        logic alloc_step;  // Write one newly allocated node.
        logic query_init;  // Restart at the root for the xor query.
        logic query_step;  // Follow the opposite bit where possible.
        logic finish;      // Load the result register and close the item.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic miss;        // The value's own child is null at this level.
        logic no_room;     // The missing nodes do not fit in the store.
        logic lvl_zero;    // The walk is at the lowest bit.
        logic q_stop;      // Both children are null during the query.
        logic out_busy;    // The result register holds a word not yet taken.
    } t_status;

endpackage

[rtl/mxt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used as the trie node store. Depends on nothing.
module mxt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/mxt_ctrl.sv]
// Controller state machine for the maximum-XOR-pair trie block.
// Sequences walk, insert, query and result for each word.
// Depends on mxt_pkg.
module mxt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mxt_pkg::t_status i_status,
    output mxt_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINK,
        S_ALLOC,
        S_QINIT,
        S_QUERY,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and the command for this cycle.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.miss) begin
                    n_state = i_status.no_room ? S_QINIT : S_LINK;
                end else if (i_status.lvl_zero) begin
                    n_state = S_QINIT;
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.alloc_step = 1'b1;
                if (i_status.lvl_zero) begin
                    n_state = S_QINIT;
                end
            end
            S_QINIT: begin
                o_cmd.query_init = 1'b1;
                n_state          = S_QUERY;
            end
            S_QUERY: begin
                o_cmd.query_step = 1'b1;
                if (i_status.q_stop || i_status.lvl_zero) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new word is taken only between items.
    assign o_in_ready = (r_state == S_IDLE);

endmodule

[rtl/mxt_dpath.sv]
// Datapath for the maximum-XOR-pair trie block: node store, root children,
// node counter, walk registers, running maximum and the result register.
// Depends on mxt_pkg and mxt_ram.
module mxt_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mxt_pkg::t_cmd              i_cmd,
    output mxt_pkg::t_status           o_status,
    input  logic [mxt_pkg::DATA_W-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mxt_pkg::DATA_W-1:0] o_partner_xor,
    output logic [mxt_pkg::DATA_W-1:0] o_best_xor,
    output logic                       o_store_full,
    output logic                       o_set_done
);

    // Control state.
    logic [mxt_pkg::CNT_W-1:0]      r_used;
    logic [mxt_pkg::IDX_W-1:0]      r_root0;
    logic [mxt_pkg::IDX_W-1:0]      r_root1;
    logic [mxt_pkg::VALUE_BITS-1:0] r_best;
    logic                           r_out_valid;

    // Working registers for the current word.
    logic [mxt_pkg::VALUE_BITS-1:0] r_value;
    logic                           r_last;
    logic [mxt_pkg::LVL_W-1:0]      r_level;
    logic [mxt_pkg::IDX_W-1:0]      r_cur;
    logic [mxt_pkg::IDX_W-1:0]      r_node;
    logic [mxt_pkg::NODE_W-1:0]     r_pdata;
    logic [mxt_pkg::VALUE_BITS-1:0] r_ans;
    logic                           r_full;

    // Result register.
    logic [mxt_pkg::VALUE_BITS-1:0] r_out_xor;
    logic [mxt_pkg::VALUE_BITS-1:0] r_out_best;
    logic                           r_out_full;
    logic                           r_out_done;

    // Node store ports.
    logic                           ram_wr_en;
    logic [mxt_pkg::IDX_W-1:0]      ram_wr_addr;
    logic [mxt_pkg::NODE_W-1:0]     ram_wr_data;
    logic                           ram_rd_en;
    logic [mxt_pkg::IDX_W-1:0]      ram_rd_addr;
    logic [mxt_pkg::NODE_W-1:0]     ram_rd_data;

    // Decoded children of the current node.
    logic [mxt_pkg::NODE_W-1:0]     kids;
    logic [mxt_pkg::IDX_W-1:0]      kid0;
    logic [mxt_pkg::IDX_W-1:0]      kid1;
    logic                           bit_b;
    logic [mxt_pkg::IDX_W-1:0]      kid_same;
    logic [mxt_pkg::IDX_W-1:0]      kid_opp;
    logic [mxt_pkg::LVL_W-1:0]      lvl_m1;
    logic [mxt_pkg::IDX_W-1:0]      node_nxt;
    logic [mxt_pkg::CNT_W:0]        need;
    logic [mxt_pkg::VALUE_BITS-1:0] new_best;

    mxt_ram #(
        .WIDTH (mxt_pkg::NODE_W),
        .DEPTH (mxt_pkg::NODE_CAP + 1)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // The root lives in registers; other nodes come from the store, whose
    // read was issued when the walk moved onto them.
    assign kids     = (r_cur == '0) ? {r_root1, r_root0} : ram_rd_data;
    assign kid0     = kids[mxt_pkg::IDX_W-1:0];
    assign kid1     = kids[2*mxt_pkg::IDX_W-1:mxt_pkg::IDX_W];
    assign bit_b    = r_value[r_level];
    assign kid_same = bit_b ? kid1 : kid0;
    assign kid_opp  = bit_b ? kid0 : kid1;
    assign lvl_m1   = r_level - 1'b1;
    assign node_nxt = r_node + 1'b1;

    // The path is missing level+1 nodes; they must fit next to those in use.
    assign need = {1'b0, r_used} + (mxt_pkg::CNT_W + 1)'(r_level);

    assign new_best = (r_ans > r_best) ? r_ans : r_best;

    // Status toward the controller.
    always_comb begin
        o_status          = '0;
        o_status.miss     = (kid_same == '0);
        o_status.no_room  = (need > (mxt_pkg::CNT_W + 1)'(mxt_pkg::NODE_CAP));
        o_status.lvl_zero = (r_level == '0);
        o_status.q_stop   = (kid_same == '0) && (kid_opp == '0);
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    // Node store access: reads follow the walk, writes link and allocate.
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = kid_same;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_node;
        ram_wr_data = '0;
        if (i_cmd.walk_step && (kid_same != '0)) begin
            ram_rd_en = 1'b1;
        end
        if (i_cmd.query_step) begin
            ram_rd_en   = !o_status.q_stop;
            ram_rd_addr = (kid_opp != '0) ? kid_opp : kid_same;
        end
        if (i_cmd.link && (r_cur != '0)) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_cur;
            ram_wr_data = bit_b ? {r_node, r_pdata[mxt_pkg::IDX_W-1:0]}
                                : {r_pdata[2*mxt_pkg::IDX_W-1:mxt_pkg::IDX_W], r_node};
        end
        if (i_cmd.alloc_step) begin
            ram_wr_en = 1'b1;
            // Each new node points at the next new one; the leaf is empty.
            if (r_level != '0) begin
                ram_wr_data = r_value[lvl_m1] ? {node_nxt, {mxt_pkg::IDX_W{1'b0}}}
                                              : {{mxt_pkg::IDX_W{1'b0}}, node_nxt};
            end
        end
    end

    // Working registers for one word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value[mxt_pkg::VALUE_BITS-1:0];
            r_last  <= i_last;
            r_level <= mxt_pkg::LVL_W'(mxt_pkg::VALUE_BITS - 1);
            r_cur   <= '0;
            r_full  <= 1'b0;
        end
        if (i_cmd.walk_step) begin
            if (kid_same == '0) begin
                r_pdata <= kids;
                r_node  <= r_used[mxt_pkg::IDX_W-1:0];
                r_full  <= o_status.no_room;
            end else begin
                r_cur   <= kid_same;
                r_level <= lvl_m1;
            end
        end
        if (i_cmd.alloc_step) begin
            r_node  <= node_nxt;
            r_level <= lvl_m1;
        end
        if (i_cmd.query_init) begin
            r_cur   <= '0;
            r_level <= mxt_pkg::LVL_W'(mxt_pkg::VALUE_BITS - 1);
            r_ans   <= '0;
        end
        if (i_cmd.query_step && !o_status.q_stop) begin
            r_level <= lvl_m1;
            if (kid_opp != '0) begin
                r_cur          <= kid_opp;
                r_ans[r_level] <= 1'b1;
            end else begin
                r_cur <= kid_same;
            end
        end
        if (i_cmd.finish) begin
            r_out_xor  <= r_ans;
            r_out_best <= new_best;
            r_out_full <= r_full;
            r_out_done <= r_last;
        end
    end

    // Trie bookkeeping, running maximum and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= mxt_pkg::CNT_W'(1);
            r_root0     <= '0;
            r_root1     <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.walk_step && (kid_same == '0) && !o_status.no_room) begin
                r_used <= r_used + mxt_pkg::CNT_W'(r_level) + 1'b1;
            end
            if (i_cmd.link && (r_cur == '0)) begin
                if (bit_b) begin
                    r_root1 <= r_node;
                end else begin
                    r_root0 <= r_node;
                end
            end
            // A new result may enter in the same cycle the old one is taken.
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                // The last word of a set closes it.
                if (r_last) begin
                    r_used  <= mxt_pkg::CNT_W'(1);
                    r_root0 <= '0;
                    r_root1 <= '0;
                    r_best  <= '0;
                end else begin
                    r_best <= new_best;
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_partner_xor = mxt_pkg::DATA_W'(r_out_xor);
    assign o_best_xor    = mxt_pkg::DATA_W'(r_out_best);
    assign o_store_full  = r_out_full;
    assign o_set_done    = r_out_done;

endmodule

[rtl/max_xor_pair_trie.sv]
// Maximum-XOR-pair search over a stream of values using a binary trie.
// Each input word carries a value and a last flag; each output word carries
// the value's best xor partner result, the set's running maximum, a store-full
// flag and an echo of last.
// Input and output channels use valid/ready; a word moves when both are high.
// Per word the block walks the value's path (one level per cycle), links and
// writes any missing nodes (one node store write per cycle), then walks again
// preferring the opposite bit (one level per cycle). A value whose missing
// nodes do not fit skips the link and write steps and finishes sooner. The
// next word is accepted only after the result has entered the output
// register, so the block never takes a new word while the last one is in
// progress.
// A stalled receiver costs nothing until a second result is ready; then the
// block holds that result internally, with input ready low, until the output
// register frees.
// Reset (synchronous, active low) empties the trie and clears the maximum;
// no clearing pass of the node store is needed. After a word with last set,
// the trie and the running maximum clear for the next set.
// Depends on mxt_pkg, mxt_ctrl and mxt_dpath.
module max_xor_pair_trie (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mxt_pkg::DATA_W-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mxt_pkg::DATA_W-1:0] o_partner_xor,
    output logic [mxt_pkg::DATA_W-1:0] o_best_xor,
    output logic                       o_store_full,
    output logic                       o_set_done
);

    mxt_pkg::t_cmd    cmd;
    mxt_pkg::t_status status;

    // Sequencer.
    mxt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Trie storage and arithmetic.
    mxt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_partner_xor (o_partner_xor),
        .o_best_xor    (o_best_xor),
        .o_store_full  (o_store_full),
        .o_set_done    (o_set_done)
    );

endmodule

[tb/max_xor_pair_checker.sv]
`timescale 1ns / 100ps
// Result checker for the maximum-XOR-pair trie block.
// Watches both word channels, keeps its own trie to predict every result
// word and compares it field by field. Depends on mxt_pkg.
module max_xor_pair_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [mxt_pkg::DATA_W-1:0] i_value,
    input  logic                       i_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [mxt_pkg::DATA_W-1:0] i_partner_xor,
    input  logic [mxt_pkg::DATA_W-1:0] i_best_xor,
    input  logic                       i_store_full,
    input  logic                       i_set_done,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [mxt_pkg::DATA_W-1:0] partner_xor;
        logic [mxt_pkg::DATA_W-1:0] best_xor;
        logic                       store_full;
        logic                       set_done;
    } t_xor_result;

    // Child indices per node; entry 0 holds the root's children.
    logic [mxt_pkg::IDX_W-1:0]  trie_child [0:mxt_pkg::NODE_CAP][0:1];
    logic [mxt_pkg::CNT_W-1:0]  nodes_in_use;
    logic [mxt_pkg::DATA_W-1:0] set_best;
    t_xor_result                expected_results [$];
    int                         mismatches = 0;
    int                         words_checked = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_results.size();

    // Empty the trie and the running maximum, as after reset or a last word.
    function automatic void clear_trie();
        nodes_in_use     = mxt_pkg::CNT_W'(1);
        trie_child[0][0] = '0;
        trie_child[0][1] = '0;
        set_best         = '0;
    endfunction

    // Insert one value, then search for its best xor partner.
    function automatic t_xor_result predict_pair_xor(
        input logic [mxt_pkg::DATA_W-1:0] value,
        input logic                       last
    );
        logic [mxt_pkg::VALUE_BITS-1:0] bits;
        t_xor_result                    res;
        int                             missing;
        int                             cur;
        int                             nxt;
        int                             lvl;

        bits    = value[mxt_pkg::VALUE_BITS-1:0];
        res     = '0;
        missing = 0;
        cur     = 0;

        // Count the nodes this value's path still lacks.
        for (lvl = mxt_pkg::VALUE_BITS - 1; lvl >= 0; lvl--) begin
            nxt = trie_child[cur][bits[lvl]];
            if (nxt == 0) begin
                missing = lvl + 1;
                break;
            end
            cur = nxt;
        end

        // Insertion is all or nothing: a path that does not fit is dropped.
        if (int'(nodes_in_use) - 1 + missing > mxt_pkg::NODE_CAP) begin
            res.store_full = 1'b1;
        end else begin
            cur = 0;
            for (lvl = mxt_pkg::VALUE_BITS - 1; lvl >= 0; lvl--) begin
                nxt = trie_child[cur][bits[lvl]];
                if (nxt == 0) begin
                    nxt                        = nodes_in_use;
                    nodes_in_use               = nodes_in_use + 1'b1;
                    trie_child[nxt][0]         = '0;
                    trie_child[nxt][1]         = '0;
                    trie_child[cur][bits[lvl]] = mxt_pkg::IDX_W'(nxt);
                end
                cur = nxt;
            end
        end

        // Walk again, taking the opposite bit wherever that child exists.
        if (trie_child[0][0] != 0 || trie_child[0][1] != 0) begin
            cur = 0;
            for (lvl = mxt_pkg::VALUE_BITS - 1; lvl >= 0; lvl--) begin
                nxt = trie_child[cur][!bits[lvl]];
                if (nxt != 0) begin
                    res.partner_xor[lvl] = 1'b1;
                end else begin
                    nxt = trie_child[cur][bits[lvl]];
                    if (nxt == 0) break;
                end
                cur = nxt;
            end
        end

        if (res.partner_xor > set_best) set_best = res.partner_xor;
        res.best_xor = set_best;
        res.set_done = last;

        if (last) clear_trie();
        return res;
    endfunction

    // One line per mismatch.
    task automatic report_mismatch(input string field,
                                   input logic [mxt_pkg::DATA_W-1:0] got,
                                   input logic [mxt_pkg::DATA_W-1:0] want);
        mismatches++;
        $display("%0t: result word %0d: %s is %h, expected %h",
                 $time, words_checked, field, got, want);
    endtask

    // Retire result words against the oldest prediction, then predict new ones.
    always @(posedge i_clk) begin
        t_xor_result want;
        if (!i_rst_n) begin
            clear_trie();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, partner_xor", i_partner_xor, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_partner_xor !== want.partner_xor)
                        report_mismatch("partner_xor", i_partner_xor, want.partner_xor);
                    if (i_best_xor !== want.best_xor)
                        report_mismatch("best_xor", i_best_xor, want.best_xor);
                    if (i_store_full !== want.store_full)
                        report_mismatch("store_full", mxt_pkg::DATA_W'(i_store_full),
                                        mxt_pkg::DATA_W'(want.store_full));
                    if (i_set_done !== want.set_done)
                        report_mismatch("set_done", mxt_pkg::DATA_W'(i_set_done),
                                        mxt_pkg::DATA_W'(want.set_done));
                end
                words_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                want             = predict_pair_xor(i_value, i_last);
                expected_results = {expected_results, want};
            end
        end
    end

endmodule

[tb/tb_max_xor_pair_trie.sv]
`timescale 1ns / 100ps
// Top of the testbench for the maximum-XOR-pair trie block.
// Sends value sets with random pauses on both channels and gives the verdict.
// Depends on mxt_pkg, max_xor_pair_trie and max_xor_pair_checker.
module tb_max_xor_pair_trie;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int FILL_WORDS   = 1450;
    localparam int FILL_MIXED   = 1400;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [mxt_pkg::DATA_W-1:0] i_value;
    logic                       i_last;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [mxt_pkg::DATA_W-1:0] o_partner_xor;
    logic [mxt_pkg::DATA_W-1:0] o_best_xor;
    logic                       o_store_full;
    logic                       o_set_done;

    int                         fail_count;
    int                         pending_results;
    int                         idle_cycles   = 0;
    int                         results_taken = 0;
    bit                         calm          = 1'b0;
    bit                         held_off      = 1'b0;
    logic [mxt_pkg::DATA_W-1:0] fill_values [$];

    max_xor_pair_trie DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_partner_xor (o_partner_xor),
        .o_best_xor    (o_best_xor),
        .o_store_full  (o_store_full),
        .o_set_done    (o_set_done)
    );

    max_xor_pair_checker u_result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_partner_xor (o_partner_xor),
        .i_best_xor    (o_best_xor),
        .i_store_full  (o_store_full),
        .i_set_done    (o_set_done),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Count cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (o_out_valid && i_out_ready) results_taken <= results_taken + 1;
    end

    // Watchdog: the run is stuck if nothing moves for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAIL max_xor_pair_trie");
        $finish;
    end

    // Receiver: random stalls, one long hold-off to fill the block, none at the end.
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && !held_off && results_taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, calm ? 1 : 24)) @(posedge i_clk);
            end
        end
    end

    // Offer one word, after a random pause unless in the last stretch.
    task automatic send_word(input logic [mxt_pkg::DATA_W-1:0] value, input logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_last     <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Short sets of random values, with duplicates and close neighbors mixed in.
    task automatic send_random_sets(input int words);
        int                         sent;
        int                         set_len;
        int                         k;
        logic [mxt_pkg::DATA_W-1:0] v;
        sent = 0;
        v    = $urandom;
        while (sent < words) begin
            set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            for (k = 0; k < set_len; k++) begin
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = mxt_pkg::DATA_W'(1) << $urandom_range(0, mxt_pkg::DATA_W - 1);
                    3:       v = v;
                    4, 5:    v = v ^ (mxt_pkg::DATA_W'(1)
                                      << $urandom_range(0, mxt_pkg::DATA_W - 1));
                    default: v = $urandom;
                endcase
                send_word(v, k == set_len - 1);
            end
            sent += set_len;
        end
    endtask

    initial begin
        logic [mxt_pkg::DATA_W-1:0] v;
        int                         fresh;
        int                         k;
        int                         b;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_value    <= '0;
        i_last     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of the value range, ending the set on a small value.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        // A one-word set: the value only meets itself.
        send_word(32'h1234_5678, 1'b1);
        // Alternating patterns and a repeated value.
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b1);
        // Equal values keep the best xor at zero.
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        // Single bits.
        send_word(32'h0000_0002, 1'b0);
        send_word(32'h0001_0000, 1'b0);
        send_word(32'h4000_0000, 1'b1);

        send_random_sets(150);

        // One large set that spreads its top bits to use up the node store.
        // Near the end, repeats and close neighbors test paths that still fit.
        fresh = 0;
        for (k = 0; k < FILL_WORDS; k++) begin
            if (k >= FILL_MIXED && $urandom_range(0, 2) == 0) begin
                v = fill_values[$urandom_range(0, fill_values.size() - 1)];
                if ($urandom_range(0, 1) == 1)
                    v = v ^ (mxt_pkg::DATA_W'(1) << $urandom_range(0, 5));
            end else begin
                v[mxt_pkg::DATA_W-12:0] = (mxt_pkg::DATA_W - 11)'($urandom);
                for (b = 0; b < 11; b++) v[mxt_pkg::DATA_W-1-b] = fresh[b];
                fresh++;
            end
            fill_values = {fill_values, v};
            send_word(v, k == FILL_WORDS - 1);
        end

        // Last stretch runs without pauses on either side.
        calm = 1'b1;
        send_random_sets(100);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS max_xor_pair_trie");
        else
            $display("FAIL max_xor_pair_trie");
        $finish;
    end

endmodule
